FILE: rtl/core/nsqrt_pkg.sv
`timescale 1ns / 1ps

package nsqrt_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int TOL_W      = 16;
	localparam int ITER_W     = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'b1;

	localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd1;
	localparam logic [ITER_W-1:0] ITER_RESET = 7'd16;

	// integer-part thresholds for the starting guess
	localparam int THR_W = 13;
	localparam logic [THR_W-1:0] THR_HUGE  = 13'd4500;
	localparam logic [THR_W-1:0] THR_BIG   = 13'd400;
	localparam logic [THR_W-1:0] THR_MID   = 13'd60;
	localparam logic [THR_W-1:0] THR_SMALL = 13'd17;

	// Q0.16 scale factors for the starting guess
	localparam int COEF_W = 16;
	localparam logic [COEF_W-1:0] COEF_HUGE  = 16'd1311;
	localparam logic [COEF_W-1:0] COEF_BIG   = 16'd3277;
	localparam logic [COEF_W-1:0] COEF_MID   = 16'd6554;
	localparam logic [COEF_W-1:0] COEF_SMALL = 16'd13107;
	localparam logic [COEF_W-1:0] COEF_TINY  = 16'd32768;

	typedef struct packed {
		logic load;
		logic mul;
		logic init;
		logic div_start;
		logic div_step;
		logic step;
		logic commit;
		logic out_load;
	} nsqrt_cmd_t;

	typedef struct packed {
		logic nonpos;
		logic div_last;
		logic converged;
		logic at_cap;
	} nsqrt_stat_t;

endpackage

FILE: rtl/core/nsqrt_in_if.sv
`timescale 1ns / 1ps

interface nsqrt_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

FILE: rtl/core/nsqrt_out_if.sv
`timescale 1ns / 1ps

interface nsqrt_out_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] root;
	logic                         capped;

	modport source (output valid, output root, output capped, input ready);
	modport sink (input valid, input root, input capped, output ready);
endinterface

FILE: rtl/core/nsqrt_cfg_if.sv
`timescale 1ns / 1ps

interface nsqrt_cfg_if
	import nsqrt_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/nsqrt_ctrl.sv
`timescale 1ns / 1ps

module nsqrt_ctrl
	import nsqrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  nsqrt_stat_t stat,
	output nsqrt_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_GUESS  = 7'b0000010,
		S_INIT   = 7'b0000100,
		S_DIV    = 7'b0001000,
		S_STEP   = 7'b0010000,
		S_CHECK  = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_GUESS;
				end
			end
			S_GUESS: begin
				cmd.mul = 1'b1;
				state_d = stat.nonpos ? S_FINISH : S_INIT;
			end
			S_INIT: begin
				cmd.init      = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				cmd.commit = 1'b1;
				if (stat.converged || stat.at_cap) begin
					state_d = S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/nsqrt_dp.sv
`timescale 1ns / 1ps

module nsqrt_dp
	import nsqrt_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nsqrt_cmd_t                   cmd,
	output nsqrt_stat_t                  stat,
	input  logic signed [DATA_WIDTH-1:0] value,
	input  logic [TOL_W-1:0]             tolerance_lsb,
	input  logic [ITER_W-1:0]            max_iterations,
	output logic signed [DATA_WIDTH-1:0] root,
	output logic                         capped
);

	localparam int W      = DATA_WIDTH;
	localparam int IW     = W - FRAC_BITS;
	localparam int CW     = IW + THR_W;
	localparam int PW     = W + COEF_W;
	localparam int NSTEP  = W + FRAC_BITS;
	localparam int CNT_W  = $clog2(NSTEP);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NSTEP - 1);
	localparam logic [W-1:0]     POS_MAX  = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]     ONE      = W'(1);

	logic [W-1:0]      value_q;
	logic [PW-1:0]     prod_q;
	logic [W-1:0]      x_q;
	logic [W-1:0]      nx_q;
	logic [W-1:0]      num_q;
	logic [W-1:0]      rem_q;
	logic [W-1:0]      quo_q;
	logic              sat_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic [ITER_W-1:0] iter_q;
	logic              cap_q;
	logic [W-1:0]      root_q;
	logic              capped_q;

	logic [CW-1:0]     int_part;
	logic [COEF_W-1:0] coef;
	logic [W-1:0]      guess;
	logic [W-1:0]      rem_shift;
	logic              take;
	logic [W-1:0]      quo_final;
	logic [W:0]        sum;
	logic [W-1:0]      half;
	logic [W-1:0]      nx_next;
	logic [W-1:0]      diff;
	logic [ITER_W-1:0] steps;

	// starting guess scale by magnitude
	assign int_part = {{THR_W{1'b0}}, value_q[W-1:FRAC_BITS]};

	always_comb begin
		if (int_part >= {{IW{1'b0}}, THR_HUGE}) begin
			coef = COEF_HUGE;
		end else if (int_part >= {{IW{1'b0}}, THR_BIG}) begin
			coef = COEF_BIG;
		end else if (int_part >= {{IW{1'b0}}, THR_MID}) begin
			coef = COEF_MID;
		end else if (int_part >= {{IW{1'b0}}, THR_SMALL}) begin
			coef = COEF_SMALL;
		end else begin
			coef = COEF_TINY;
		end
	end

	assign guess = (prod_q[PW-1:COEF_W] == '0) ? ONE : prod_q[PW-1:COEF_W];

	// restoring division of value << frac by the estimate, one bit a cycle
	assign rem_shift = {rem_q[W-2:0], num_q[W-1]};
	assign take      = (rem_shift >= x_q);
	assign quo_final = sat_q ? {W{1'b1}} : quo_q;

	assign sum  = {1'b0, x_q} + {1'b0, quo_final};
	assign half = sum[W:1];

	always_comb begin
		if (half[W-1]) begin
			nx_next = POS_MAX;
		end else if (half == '0) begin
			nx_next = ONE;
		end else begin
			nx_next = half;
		end
	end

	assign diff  = (nx_q >= x_q) ? (nx_q - x_q) : (x_q - nx_q);
	assign steps = (max_iterations == '0) ? ITER_W'(1) : max_iterations;

	assign stat.nonpos    = (value_q == '0) || value_q[W-1];
	assign stat.div_last  = (div_cnt_q == CNT_LAST);
	assign stat.converged = (diff <= W'(tolerance_lsb));
	assign stat.at_cap    = (iter_q == steps);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
		end
		if (cmd.mul) begin
			prod_q <= PW'(value_q) * PW'(coef);
		end
		if (cmd.init) begin
			x_q <= guess;
		end else if (cmd.commit) begin
			x_q <= nx_q;
		end
		if (cmd.div_start) begin
			num_q <= value_q;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[W-2:0], 1'b0};
			rem_q <= take ? (rem_shift - x_q) : rem_shift;
			quo_q <= {quo_q[W-2:0], take};
			sat_q <= sat_q | quo_q[W-1];
		end
		if (cmd.step) begin
			nx_q <= nx_next;
		end
		if (cmd.out_load) begin
			root_q   <= stat.nonpos ? value_q : x_q;
			capped_q <= cap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			iter_q    <= '0;
			cap_q     <= 1'b0;
		end else begin
			if (cmd.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + CNT_W'(1);
			end
			if (cmd.mul) begin
				iter_q <= '0;
			end else if (cmd.step) begin
				iter_q <= iter_q + ITER_W'(1);
			end
			if (cmd.load) begin
				cap_q <= 1'b0;
			end else if (cmd.commit) begin
				cap_q <= !stat.converged;
			end
		end
	end

	assign root   = root_q;
	assign capped = capped_q;

	a_guess_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init |=> (x_q != '0))
		else $error("starting guess is zero");

	a_estimate_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> ((x_q != '0) && !x_q[W-1]))
		else $error("estimate out of range after update");

	a_step_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (iter_q < steps))
		else $error("newton step issued past the iteration cap");

endmodule

FILE: rtl/core/newton_square_root.sv
`timescale 1ns / 1ps

// Fixed-point square root by Newton steps (signed, FRAC_BITS fraction bits).
// operand: one word per value, taken when valid and ready are high; ready is
// high only while no value is in progress.
// result: one word per operand, root and capped flag, held in an output
// register until taken, so a new operand is accepted while it waits.
// cfg: tolerance_lsb (index 0) and max_iterations (index 1), always ready;
// write only while idle. Reset restores 1 and 16 and empties the block.
// Sequence from acceptance to result valid:
//   operand zero or negative: S_GUESS, then S_FINISH loads the output register;
//   otherwise: S_GUESS, S_INIT, then per Newton step the one-bit-a-cycle divider
//   (S_DIV), S_STEP and S_CHECK, then S_FINISH loads the output register.
// Throughput: one operand at a time; the next is accepted on the cycle after
// the result is loaded into the output register.
// A stalled receiver holds the result; a finished computation waits for the
// output register to free before loading.

module newton_square_root
	import nsqrt_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	nsqrt_in_if.sink    operand,
	nsqrt_out_if.source result,
	nsqrt_cfg_if.sink   cfg
);

	logic [TOL_W-1:0]  tolerance_q;
	logic [ITER_W-1:0] max_iter_q;
	nsqrt_cmd_t        cmd;
	nsqrt_stat_t       stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
			max_iter_q  <= ITER_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TOLERANCE: tolerance_q <= cfg.data[TOL_W-1:0];
				REG_MAX_ITER:  max_iter_q  <= cfg.data[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	nsqrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operand.valid),
		.in_ready  (operand.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	nsqrt_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.value          (operand.value),
		.tolerance_lsb  (tolerance_q),
		.max_iterations (max_iter_q),
		.root           (result.root),
		.capped         (result.capped)
	);

endmodule
